@@ rtl/tremolo_sine_modulator_unit_assert.svh @@
// Assertion macros shared by the checker files.
`ifndef TREMOLO_SINE_MODULATOR_UNIT_ASSERT_SVH
`define TREMOLO_SINE_MODULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSM_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("tsm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSM_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tsm assertion failed");

`endif

@@ rtl/tsm_pkg.sv @@
package tsm_pkg;

   localparam int INDEX_BITS_DEFAULT    = 10;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int SAMPLE_BITS = 16;
   localparam int BYTE_BITS   = 8;
   localparam int RATE_BITS   = 8;
   localparam int MAG_BITS    = 15;

   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP       = 16'h8000;
   localparam logic [RATE_BITS-1:0]   RATE_STEP_RESET = 8'd20;

   // pi/2 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // (2n)(2n+1) for the odd Taylor terms x^3 .. x^13
   localparam logic [7:0] TAYLOR_DIVISOR [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

   // One quarter-wave entry, evaluated at elaboration only.
   function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned k,
                                                        input int unsigned index_bits);
      logic [63:0]        x;
      logic [63:0]        term;
      logic [63:0]        rounded;
      logic signed [63:0] sum;
      x    = (HALF_PI_Q30 * 64'(k)) >> (index_bits - 2);
      term = x;
      sum  = signed'(x);
      for (int n = 0; n < 6; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'(TAYLOR_DIVISOR[n]);
         if ((n & 1) == 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rounded = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[MAG_BITS-1:0];
   endfunction

endpackage

@@ rtl/tremolo_sine_modulator_unit.sv @@
// Tremolo sine modulator. One beat in on req_, one beat out on rsp_,
// rsp_valid rises in the cycle after acceptance, and a new beat can be
// taken every cycle; while a response waits, the next beat is taken in
// the cycle in which rsp_ready drains it.
// Each response carries the result of the previous request (a one-sample
// delay), so the first response after reset is silence: pwm_high 0x80,
// pwm_low 0x00. The rate is set by the 16x17 signed multiply that runs
// from the sample and amplitude registers into the response register; the
// phase step and sine lookup sit in the stage before it. csr_write_data
// sets the phase step per sample (tremolo speed); write it only while idle.
module tremolo_sine_modulator_unit #(
   parameter int INDEX_BITS    = tsm_pkg::INDEX_BITS_DEFAULT,
   parameter int FRACTION_BITS = tsm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tsm_pkg::RATE_BITS-1:0]     csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tsm_pkg::SAMPLE_BITS-1:0]   req_adc_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tsm_pkg::BYTE_BITS-1:0]     rsp_pwm_high,
   output logic [tsm_pkg::BYTE_BITS-1:0]     rsp_pwm_low
);

   localparam int SAMPLE_BITS  = tsm_pkg::SAMPLE_BITS;
   localparam int BYTE_BITS    = tsm_pkg::BYTE_BITS;
   localparam int SUM_BITS     = ((FRACTION_BITS > tsm_pkg::RATE_BITS) ?
                                  FRACTION_BITS : tsm_pkg::RATE_BITS) + 1;
   localparam int QADDR_BITS   = INDEX_BITS - 1;
   localparam int QUARTER_SIZE = 1 << (INDEX_BITS - 2);
   localparam int PROD_BITS    = 2 * SAMPLE_BITS + 1;
   localparam logic [QADDR_BITS-1:0] QUARTER_LAST = QADDR_BITS'(QUARTER_SIZE);

   // quarter-wave sine magnitudes, entries 0 .. QUARTER_SIZE inclusive
   logic [tsm_pkg::MAG_BITS-1:0] quarter_rom [QUARTER_SIZE+1];

   for (genvar g = 0; g <= QUARTER_SIZE; g++) begin : g_quarter
      assign quarter_rom[g] = tsm_pkg::quarter_sine(g, INDEX_BITS);
   end

   // control / state
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tsm_pkg::RATE_BITS-1:0] rate_step_ff;
   logic [FRACTION_BITS-1:0]      phase_fraction_ff, phase_fraction_in;
   logic [INDEX_BITS-1:0]         phase_index_ff, phase_index_in;
   // sample of the last request and its gain; their product is the
   // delayed result (zero after reset since the sample resets to zero)
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]        amp_ff, amp_in;
   logic [BYTE_BITS-1:0]          pwm_high_ff, pwm_high_in;
   logic [BYTE_BITS-1:0]          pwm_low_ff, pwm_low_in;

   logic                          accept;
   logic [SUM_BITS-1:0]           frac_sum;
   logic                          carry;
   logic [1:0]                    quadrant;
   logic [QADDR_BITS-1:0]         quarter_addr;
   logic [SAMPLE_BITS-1:0]        magnitude;
   logic [SAMPLE_BITS-1:0]        sine_word;
   logic signed [PROD_BITS-1:0]   product;
   logic [SAMPLE_BITS-1:0]        result;
   logic [SAMPLE_BITS-1:0]        result_offset;

   // skid-free output register: accept whenever the slot is empty or drains
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // phase step and sine lookup for this beat
   always_comb begin
      frac_sum          = SUM_BITS'(phase_fraction_ff) + SUM_BITS'(rate_step_ff);
      carry             = |frac_sum[SUM_BITS-1:FRACTION_BITS];
      phase_fraction_in = frac_sum[FRACTION_BITS-1:0];
      phase_index_in    = phase_index_ff + INDEX_BITS'(carry);

      quadrant = phase_index_in[INDEX_BITS-1 -: 2];
      // odd quadrants run the quarter wave backward
      if (quadrant[0]) begin
         quarter_addr = QUARTER_LAST - {1'b0, phase_index_in[INDEX_BITS-3:0]};
      end else begin
         quarter_addr = {1'b0, phase_index_in[INDEX_BITS-3:0]};
      end
      magnitude = {1'b0, quarter_rom[quarter_addr]};
      sine_word = quadrant[1] ? (~magnitude + 1'b1) : magnitude;
      amp_in    = sine_word ^ tsm_pkg::SIGN_FLIP;
      sample_in = signed'(req_adc_word ^ tsm_pkg::SIGN_FLIP);
   end

   // previous beat's gain applied to previous beat's sample -> response
   always_comb begin
      product       = sample_ff * signed'({1'b0, amp_ff});
      result        = product[2*SAMPLE_BITS-1:SAMPLE_BITS];
      result_offset = result ^ tsm_pkg::SIGN_FLIP;
      pwm_high_in   = result_offset[SAMPLE_BITS-1:BYTE_BITS];
      pwm_low_in    = result[BYTE_BITS-1:0];
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         rate_step_ff      <= tsm_pkg::RATE_STEP_RESET;
         phase_fraction_ff <= '0;
         phase_index_ff    <= '0;
         sample_ff         <= '0;
         amp_ff            <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            rate_step_ff <= csr_write_data;
         end
         if (accept) begin
            phase_fraction_ff <= phase_fraction_in;
            phase_index_ff    <= phase_index_in;
            sample_ff         <= sample_in;
            amp_ff            <= amp_in;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         pwm_high_ff <= pwm_high_in;
         pwm_low_ff  <= pwm_low_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pwm_high = pwm_high_ff;
   assign rsp_pwm_low  = pwm_low_ff;

endmodule

@@ rtl/tsm_checker.sv @@
`include "tremolo_sine_modulator_unit_assert.svh"

module tsm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tsm_pkg::BYTE_BITS-1:0]   rsp_pwm_high,
   input logic [tsm_pkg::BYTE_BITS-1:0]   rsp_pwm_low
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled response holds
   `TSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                    rsp_valid && $stable(rsp_pwm_high) && $stable(rsp_pwm_low))

   // the input side is open exactly when the output slot is free or drains
   `TSM_ASSERT_NOW(a_ready_rule, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   // every accepted request shows a response in the next cycle
   `TSM_ASSERT_NEXT(a_beat_to_rsp, clock, reset, req_beat, rsp_valid)

   // no response appears without a request
   `TSM_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_valid && !req_beat, !rsp_valid)

endmodule

bind tremolo_sine_modulator_unit tsm_checker u_tsm_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

// Tremolo sine modulator testbench.
//
// Drives raw converter words into the req_ channel and checks every rsp_ beat
// against a cycle-free model of the modulator. The model has its own quarter-wave
// sine table build, its own phase accumulator, and its own one-sample result
// delay. Expected PWM byte pairs are queued on each accepted request beat and
// checked against each accepted response beat, in order.
//
// The sequence is directed extremes, then rate-step corner values, then random
// streams under three backpressure profiles. The last stream runs at the
// fastest rate long enough to wrap the phase index through the whole table.
module testbench;

   localparam int IDX_BITS   = 10;
   localparam int FRAC_BITS  = 8;
   localparam int TABLE_SIZE = 1 << IDX_BITS;
   localparam int QUARTER    = TABLE_SIZE / 4;
   localparam longint unsigned PI_OVER_2_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [tsm_pkg::BYTE_BITS-1:0] pwm_high;
      logic [tsm_pkg::BYTE_BITS-1:0] pwm_low;
   } pwm_pair_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [tsm_pkg::RATE_BITS-1:0]   csr_write_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [tsm_pkg::SAMPLE_BITS-1:0] req_adc_word = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [tsm_pkg::BYTE_BITS-1:0]   rsp_pwm_high;
   logic [tsm_pkg::BYTE_BITS-1:0]   rsp_pwm_low;

   // Model state, mirrors the block's phase accumulator and delay register.
   logic [tsm_pkg::SAMPLE_BITS-1:0] sine_table [TABLE_SIZE];
   logic [FRAC_BITS-1:0]            lfo_fraction = '0;
   logic [IDX_BITS-1:0]             lfo_index = '0;
   logic [tsm_pkg::SAMPLE_BITS-1:0] held_result = '0;
   logic [tsm_pkg::RATE_BITS-1:0]   lfo_rate = tsm_pkg::RATE_STEP_RESET;

   pwm_pair_type pending_pwm [$];
   int           mismatch_count = 0;

   // Backpressure profile, percent of cycles spent idle or stalled.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   tremolo_sine_modulator_unit #(
      .INDEX_BITS    (IDX_BITS),
      .FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_word     (req_adc_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pwm_high     (rsp_pwm_high),
      .rsp_pwm_low      (rsp_pwm_low)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Quarter-wave magnitude: Taylor series of sin(x) up to x^13 in Q30,
   // every product and divide truncated, then scaled to 15 bits with
   // round-half-up and clamped to full scale.
   function automatic logic [tsm_pkg::SAMPLE_BITS-1:0] sine_magnitude(input int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned scaled;
      longint          acc;
      x    = (PI_OVER_2_Q30 * longint'(k)) / QUARTER;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      scaled = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (scaled > 64'd32767) begin
         scaled = 64'd32767;
      end
      return scaled[tsm_pkg::SAMPLE_BITS-1:0];
   endfunction

   // Full period: rising quarter, falling quarter, then the negated pair.
   function automatic void build_sine_table();
      logic [tsm_pkg::SAMPLE_BITS-1:0] mag;
      int                              quad;
      int                              k;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         quad = (i / QUARTER) % 4;
         k    = i % QUARTER;
         mag  = (quad % 2 == 1) ? sine_magnitude(QUARTER - k) : sine_magnitude(k);
         sine_table[i] = (quad >= 2) ? tsm_pkg::SAMPLE_BITS'(0 - mag) : mag;
      end
   endfunction

   // One sample through the modulator. Returns the bytes of the result held
   // from the previous sample, then advances the LFO and stores the new one.
   function automatic pwm_pair_type tremolo_step(
      input logic [tsm_pkg::SAMPLE_BITS-1:0] adc_word);
      pwm_pair_type                           pair;
      logic [tsm_pkg::SAMPLE_BITS-1:0]        offset_result;
      logic signed [tsm_pkg::SAMPLE_BITS-1:0] sample;
      logic [FRAC_BITS:0]                     frac_sum;
      logic [tsm_pkg::SAMPLE_BITS-1:0]        gain;
      longint                                 product;
      offset_result = held_result ^ tsm_pkg::SIGN_FLIP;
      pair.pwm_high = offset_result[15:8];
      pair.pwm_low  = held_result[7:0];
      sample   = signed'(adc_word ^ tsm_pkg::SIGN_FLIP);
      frac_sum = {1'b0, lfo_fraction} + (FRAC_BITS + 1)'(lfo_rate);
      // carry out of the fraction moves the table pointer by one, wrapping
      if (frac_sum[FRAC_BITS]) begin
         lfo_index = lfo_index + 1'b1;
      end
      lfo_fraction = frac_sum[FRAC_BITS-1:0];
      // signed sine word to unsigned gain, then keep the high half (floor)
      gain        = sine_table[lfo_index] ^ tsm_pkg::SIGN_FLIP;
      product     = longint'(sample) * longint'(gain);
      held_result = product[31:16];
      return pair;
   endfunction

   // Receiver: stall at random according to the current profile.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Scoreboard: queue the prediction on each request beat, compare each
   // response beat with the oldest prediction.
   always @(posedge clock) begin
      pwm_pair_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_pwm.push_back(tremolo_step(req_adc_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_pwm.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with nothing pending, got high %02h low %02h",
                        $time, rsp_pwm_high, rsp_pwm_low);
            end else begin
               want = pending_pwm.pop_front();
               if (rsp_pwm_high !== want.pwm_high) begin
                  mismatch_count++;
                  $display("%0t: pwm_high mismatch, expected %02h, got %02h",
                           $time, want.pwm_high, rsp_pwm_high);
               end
               if (rsp_pwm_low !== want.pwm_low) begin
                  mismatch_count++;
                  $display("%0t: pwm_low mismatch, expected %02h, got %02h",
                           $time, want.pwm_low, rsp_pwm_low);
               end
            end
         end
      end
   end

   // Present one word, after a random idle gap, and hold it until the beat
   // is taken. Valid stays high on return so back-to-back beats need no
   // extra edge.
   task automatic send_adc_word(input logic [tsm_pkg::SAMPLE_BITS-1:0] word);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_adc_word <= word;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Stop sending and wait for every pending response, plus a short tail
   // so the pipeline is empty before any register write.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pwm.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_rate(input logic [tsm_pkg::RATE_BITS-1:0] rate);
      csr_write_enable <= 1'b1;
      csr_write_data   <= rate;
      lfo_rate = rate;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= tsm_pkg::RATE_BITS'($urandom_range(0, 255));
      @(posedge clock);
   endtask

   // Full-scale and mid-scale words at the reset rate; the first response
   // must be silence from the cleared delay register.
   task automatic test_reset_and_extremes();
      logic [tsm_pkg::SAMPLE_BITS-1:0] words [12] = '{
         16'h8000, 16'h0000, 16'hffff, 16'h7fff, 16'h8001, 16'h0001,
         16'hfffe, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h8000
      };
      foreach (words[i]) begin
         send_adc_word(words[i]);
      end
      wait_until_drained();
   endtask

   // Rate corners: zero freezes the LFO, 255 steps the index almost every
   // beat, one and mid-scale in between.
   task automatic test_rate_extremes();
      logic [tsm_pkg::RATE_BITS-1:0] rates [4] = '{8'd0, 8'd255, 8'd1, 8'd128};
      foreach (rates[r]) begin
         write_rate(rates[r]);
         for (int i = 0; i < 3; i++) begin
            send_adc_word((i == 0) ? 16'hffff : ((i == 1) ? 16'h0000 : 16'h7fff));
         end
         wait_until_drained();
      end
   endtask

   // Random words with a bias toward the rails, at the given rate, under the
   // given backpressure profile. Occasionally the sender holds off until
   // everything in flight has come back.
   task automatic test_random_stream(input int beats, input int idle_pct, input int stall_pct,
                                     input logic [tsm_pkg::RATE_BITS-1:0] rate);
      logic [tsm_pkg::SAMPLE_BITS-1:0] word;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      write_rate(rate);
      for (int i = 0; i < beats; i++) begin
         case ($urandom_range(0, 9))
            0: word = 16'h0000;
            1: word = 16'hffff;
            2: word = 16'h8000 ^ tsm_pkg::SAMPLE_BITS'($urandom_range(0, 3));
            default: word = tsm_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
         endcase
         send_adc_word(word);
         if ($urandom_range(0, 99) == 0) begin
            wait_until_drained();
         end
      end
      wait_until_drained();
   endtask

   initial begin
      build_sine_table();
      send_idle_pct = 21;
      rsp_stall_pct = 81;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_and_extremes();
      test_rate_extremes();
      test_random_stream(300, 21, 81, tsm_pkg::RATE_BITS'($urandom_range(2, 254)));
      test_random_stream(300, 81, 21, tsm_pkg::RATE_BITS'($urandom_range(2, 254)));
      // fastest rate with no idling: the index wraps past the table end
      test_random_stream(1100, 0, 0, 8'd255);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_pwm.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
